// ===== hw/rtl/qat_pkg.sv =====
// Shared types, codes and character helpers for the argument tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package qat_pkg;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_EOT  = 2'd1;
	localparam logic [1:0] KIND_EOL  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OPEN_Q   = 2'd1;
	localparam logic [1:0] ST_TRAIL_BS = 2'd2;
	localparam logic [1:0] ST_TOO_MANY = 2'd3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ESC    = 8'h1B;

	localparam logic [7:0] MAX_TOKENS_RST = 8'd16;

	// One queue entry: first result, plus an end of line that follows it when two is set.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic [7:0] num;
		logic [1:0] status;
		logic       two;
	} entry_t;

	function automatic logic is_sep(input logic [7:0] b);
		is_sep = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
			(b == 8'h0B) || (b == 8'h0C);
	endfunction

	function automatic logic [7:0] decode_escape(input logic [7:0] b);
		case (b)
			8'h6E: decode_escape = 8'h0A;
			8'h72: decode_escape = 8'h0D;
			8'h74: decode_escape = 8'h09;
			8'h61: decode_escape = 8'h07;
			8'h62: decode_escape = 8'h08;
			8'h66: decode_escape = 8'h0C;
			8'h76: decode_escape = 8'h0B;
			8'h65: decode_escape = CH_ESC;
			default: decode_escape = b;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/quoted_argument_tokenizer.sv =====
// Top level of the shell-style quoted argument tokenizer.
// Takes one line byte per cycle and streams token characters, end-of-token marks
// and an end-of-line status (byte 0 ends the line). A byte moves in one transfer
// every cycle while the result queue has room; the parser decides each byte
// combinationally, so bytes run back to back. The back end sends one result per
// cycle while result_stall is low, so a line end that closes a bare token (two
// results) holds its entry, and the QUEUE_DEPTH-entry queue absorbs that. A byte's
// first result passes the queue and then the output register. Bytes that give no
// result (separators outside a token, quotes, bytes after an error) leave the
// queue untouched. max_tokens, written via cfg_wr_en / cfg_wr_data, resets to 16.
`timescale 1ns / 1ps
`default_nettype none
module quoted_argument_tokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] line_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      kind,
	output logic [7:0]      char_out,
	output logic [7:0]      token_number,
	output logic [1:0]      status,
	output logic            last_of_item
);

	logic            q_full;
	logic            take;
	logic            push;
	logic            pop;
	logic            head_valid;
	qat_pkg::entry_t push_entry;
	qat_pkg::entry_t head;

	assign byte_stall = q_full;
	assign take       = byte_valid && !q_full;

	qat_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.take        (take),
		.line_byte   (line_byte),
		.push_entry  (push_entry),
		.push        (push)
	);

	qat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_entry),
		.full      (q_full),
		.pop       (pop),
		.dout      (head),
		.not_empty (head_valid)
	);

	qat_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.char_out     (char_out),
		.token_number (token_number),
		.status       (status),
		.last_of_item (last_of_item)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/qat_front.sv =====
// Front end: takes line bytes, runs the quoting state machine, queues results.
`timescale 1ns / 1ps
`default_nettype none
module qat_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [7:0]       cfg_wr_data,
	input  wire logic             take,
	input  wire logic [7:0]       line_byte,
	output qat_pkg::entry_t       push_entry,
	output logic                  push
);

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_BARE    = 3'd1;
	localparam logic [2:0] MODE_BARE_ESC = 3'd2;
	localparam logic [2:0] MODE_SQ      = 3'd3;
	localparam logic [2:0] MODE_DQ      = 3'd4;
	localparam logic [2:0] MODE_DQ_ESC  = 3'd5;

	logic [7:0] max_q;
	logic [2:0] mode_q, mode_d;
	logic [7:0] count_q, count_d;
	logic [1:0] err_q, err_d;
	logic       ovf_q, ovf_d;
	logic       emit;
	qat_pkg::entry_t e;

	always_comb begin
		logic start_ovf;
		start_ovf = (count_q >= max_q);
		mode_d  = mode_q;
		count_d = count_q;
		err_d   = err_q;
		ovf_d   = ovf_q;
		emit    = 1'b0;
		e.kind   = qat_pkg::KIND_CHAR;
		e.ch     = qat_pkg::CH_NUL;
		e.num    = count_q;
		e.status = qat_pkg::ST_OK;
		e.two    = 1'b0;
		if (line_byte == qat_pkg::CH_NUL) begin
			emit   = 1'b1;
			e.kind = qat_pkg::KIND_EOL;
			if (err_q == qat_pkg::ST_OK) begin
				unique case (mode_q) inside
					MODE_BARE: begin
						if (ovf_q) begin
							err_d = qat_pkg::ST_TOO_MANY;
						end else begin
							e.kind = qat_pkg::KIND_EOT;
							e.two  = 1'b1;
						end
					end
					MODE_BARE_ESC, MODE_DQ_ESC: err_d = qat_pkg::ST_TRAIL_BS;
					MODE_SQ, MODE_DQ: err_d = qat_pkg::ST_OPEN_Q;
					default: ;
				endcase
			end
			e.status = e.two ? qat_pkg::ST_OK : err_d;
			mode_d  = MODE_IDLE;
			count_d = '0;
			err_d   = qat_pkg::ST_OK;
			ovf_d   = 1'b0;
		end else if (err_q == qat_pkg::ST_OK) begin
			unique case (mode_q)
				MODE_BARE: begin
					if (qat_pkg::is_sep(line_byte)) begin
						mode_d = MODE_IDLE;
						if (ovf_q) begin
							err_d = qat_pkg::ST_TOO_MANY;
						end else begin
							emit    = 1'b1;
							e.kind  = qat_pkg::KIND_EOT;
							count_d = count_q + 8'd1;
						end
					end else if (line_byte == qat_pkg::CH_SQUOTE) begin
						mode_d = MODE_SQ;
					end else if (line_byte == qat_pkg::CH_DQUOTE) begin
						mode_d = MODE_DQ;
					end else if (line_byte == qat_pkg::CH_BSLASH) begin
						mode_d = MODE_BARE_ESC;
					end else begin
						emit = !ovf_q;
						e.ch = line_byte;
					end
				end
				MODE_BARE_ESC: begin
					emit   = !ovf_q;
					e.ch   = qat_pkg::decode_escape(line_byte);
					mode_d = MODE_BARE;
				end
				MODE_SQ: begin
					if (line_byte == qat_pkg::CH_SQUOTE) begin
						mode_d = MODE_BARE;
					end else begin
						emit = !ovf_q;
						e.ch = line_byte;
					end
				end
				MODE_DQ: begin
					if (line_byte == qat_pkg::CH_DQUOTE) begin
						mode_d = MODE_BARE;
					end else if (line_byte == qat_pkg::CH_BSLASH) begin
						mode_d = MODE_DQ_ESC;
					end else begin
						emit = !ovf_q;
						e.ch = line_byte;
					end
				end
				MODE_DQ_ESC: begin
					emit   = !ovf_q;
					e.ch   = qat_pkg::decode_escape(line_byte);
					mode_d = MODE_DQ;
				end
				default: begin
					if (qat_pkg::is_sep(line_byte)) begin
						mode_d = MODE_IDLE;
					end else begin
						ovf_d = start_ovf;
						if (line_byte == qat_pkg::CH_SQUOTE) begin
							mode_d = MODE_SQ;
						end else if (line_byte == qat_pkg::CH_DQUOTE) begin
							mode_d = MODE_DQ;
						end else if (line_byte == qat_pkg::CH_BSLASH) begin
							mode_d = MODE_BARE_ESC;
						end else begin
							mode_d = MODE_BARE;
							emit   = !start_ovf;
							e.ch   = line_byte;
						end
					end
				end
			endcase
		end
	end

	assign push       = take && emit;
	assign push_entry = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= qat_pkg::MAX_TOKENS_RST;
			mode_q  <= MODE_IDLE;
			count_q <= '0;
			err_q   <= qat_pkg::ST_OK;
			ovf_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (take) begin
				mode_q  <= mode_d;
				count_q <= count_d;
				err_q   <= err_d;
				ovf_q   <= ovf_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/qat_queue.sv =====
// Small register queue of result entries between front and back.
`timescale 1ns / 1ps
`default_nettype none
module qat_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  qat_pkg::entry_t      din,
	output logic                 full,
	input  wire logic            pop,
	output qat_pkg::entry_t      dout,
	output logic                 not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qat_pkg::entry_t     mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/qat_back.sv =====
// Back end: expands queued entries into results and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module qat_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  qat_pkg::entry_t      head,
	input  wire logic            head_valid,
	output logic                 pop,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output logic [1:0]           kind,
	output logic [7:0]           char_out,
	output logic [7:0]           token_number,
	output logic [1:0]           status,
	output logic                 last_of_item
);

	logic       load;
	logic       phase_q;
	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] char_q;
	logic [7:0] num_q;
	logic [1:0] status_q;
	logic       last_q;

	assign load = head_valid && (!valid_q || !result_stall);
	assign pop  = load && (!head.two || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= head.two && !phase_q;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (phase_q) begin
				kind_q   <= qat_pkg::KIND_EOL;
				char_q   <= qat_pkg::CH_NUL;
				num_q    <= head.num + 8'd1;
				status_q <= qat_pkg::ST_OK;
				last_q   <= 1'b1;
			end else begin
				kind_q   <= head.kind;
				char_q   <= head.ch;
				num_q    <= head.num;
				status_q <= head.status;
				last_q   <= !head.two;
			end
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign char_out     = char_q;
	assign token_number = num_q;
	assign status       = status_q;
	assign last_of_item = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/qat_checker.sv =====
// Port-level checker for the tokenizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qat_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] char_out,
	input wire logic [7:0] token_number,
	input wire logic [1:0] status,
	input wire logic       last_of_item
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind) &&
		$stable(char_out) && $stable(token_number) && $stable(status) &&
		$stable(last_of_item))
		else $error("stalled result changed");

	a_eol_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == qat_pkg::KIND_EOL |-> last_of_item)
		else $error("end of line not last of its byte");

	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_item |-> kind == qat_pkg::KIND_EOT && status == qat_pkg::ST_OK)
		else $error("non-final result is not an end of token");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last_of_item |=>
		!(result_valid && kind == qat_pkg::KIND_CHAR))
		else $error("end of line missing after leading end of token");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> kind != 2'd3 && (kind == qat_pkg::KIND_CHAR || char_out == 8'd0) &&
		(kind == qat_pkg::KIND_EOL || status == qat_pkg::ST_OK))
		else $error("result fields inconsistent with kind");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.kind         (kind),
	.char_out     (char_out),
	.token_number (token_number),
	.status       (status),
	.last_of_item (last_of_item)
);
`default_nettype wire
